// File: src/wsdf_pkg.sv
// shared types and constants for the websocket frame deframer
`timescale 1ns / 1ps
`default_nettype none
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  localparam logic [3:0] OPCODE_MASK  = 4'hf;
  localparam int         MASK_BIT     = 7;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam logic [2:0] EXT16_LAST   = 3'd1;
  localparam logic [2:0] EXT64_LAST   = 3'd7;
  localparam logic [2:0] KEY_LAST     = 3'd3;

endpackage
`default_nettype wire

// File: src/websocket_frame_deframer_core.sv
// websocket receive deframer: header parse, unmasking and payload output
//
// Takes one received byte per clock on the rx channel and parses back-to-back
// RFC 6455 frames: opcode, mask bit, 7/16/64-bit length and optional 4-byte
// masking key. Each payload byte leaves unmasked on the result channel with the
// frame opcode and a last flag; a frame with no payload gives one result with
// empty_frame set. Header bytes give no result. Throughput is one byte per
// cycle; the parser state and the result register both update at the rx
// transfer, and rx_ready only drops while the result register is full and
// result_ready is low. FIN and RSV bits are ignored.
`timescale 1ns / 1ps
`default_nettype none
module websocket_frame_deframer_core
  import wsdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_ready,
  input  wire logic [7:0] rx_byte,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [7:0]      payload_byte,
  output logic [3:0]      frame_opcode,
  output logic            frame_last,
  output logic            empty_frame
);

  phase_t      parse_phase, parse_phase_next;
  logic [3:0]  held_opcode, held_opcode_next;
  logic        masked_flag, masked_flag_next;
  logic [2:0]  field_byte_count, field_byte_count_next;
  logic [63:0] remaining_length, remaining_length_next;
  logic [31:0] masking_key, masking_key_next;
  logic [1:0]  key_index, key_index_next;

  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        emit_empty;

  logic        rx_xfer;
  logic [63:0] length_shift;
  logic [63:0] length_dec;
  logic [6:0]  len7;
  logic [7:0]  key_byte;

  assign rx_ready     = !result_valid || result_ready;
  assign rx_xfer      = rx_valid && rx_ready;
  assign length_shift = {remaining_length[55:0], rx_byte};
  assign length_dec   = remaining_length - 64'd1;
  assign len7         = rx_byte[6:0];

  always_comb begin
    case (key_index)
      2'd0:    key_byte = masking_key[31:24];
      2'd1:    key_byte = masking_key[23:16];
      2'd2:    key_byte = masking_key[15:8];
      default: key_byte = masking_key[7:0];
    endcase
  end

  always_comb begin
    parse_phase_next      = parse_phase;
    held_opcode_next      = held_opcode;
    masked_flag_next      = masked_flag;
    field_byte_count_next = field_byte_count;
    remaining_length_next = remaining_length;
    masking_key_next      = masking_key;
    key_index_next        = key_index;
    emit       = 1'b0;
    emit_byte  = 8'd0;
    emit_last  = 1'b0;
    emit_empty = 1'b0;

    case (parse_phase)
      PH_HDR1: begin
        masked_flag_next      = rx_byte[MASK_BIT];
        field_byte_count_next = 3'd0;
        if (len7 == LEN_EXT16) begin
          remaining_length_next = 64'd0;
          parse_phase_next      = PH_EXT16;
        end else if (len7 == LEN_EXT64) begin
          remaining_length_next = 64'd0;
          parse_phase_next      = PH_EXT64;
        end else begin
          remaining_length_next = {57'd0, len7};
          key_index_next        = 2'd0;
          if (rx_byte[MASK_BIT]) begin
            parse_phase_next = PH_KEY;
          end else if (len7 == 7'd0) begin
            emit             = 1'b1;
            emit_last        = 1'b1;
            emit_empty       = 1'b1;
            parse_phase_next = PH_HDR0;
          end else begin
            parse_phase_next = PH_DATA;
          end
        end
      end

      PH_EXT16, PH_EXT64: begin
        remaining_length_next = length_shift;
        if ((parse_phase == PH_EXT16 && field_byte_count >= EXT16_LAST) ||
            (parse_phase == PH_EXT64 && field_byte_count >= EXT64_LAST)) begin
          field_byte_count_next = 3'd0;
          key_index_next        = 2'd0;
          if (masked_flag) begin
            parse_phase_next = PH_KEY;
          end else if (length_shift == 64'd0) begin
            emit             = 1'b1;
            emit_last        = 1'b1;
            emit_empty       = 1'b1;
            parse_phase_next = PH_HDR0;
          end else begin
            parse_phase_next = PH_DATA;
          end
        end else begin
          field_byte_count_next = field_byte_count + 3'd1;
        end
      end

      PH_KEY: begin
        masking_key_next = {masking_key[23:0], rx_byte};
        if (field_byte_count < KEY_LAST) begin
          field_byte_count_next = field_byte_count + 3'd1;
        end else begin
          field_byte_count_next = 3'd0;
          key_index_next        = 2'd0;
          if (remaining_length == 64'd0) begin
            emit             = 1'b1;
            emit_last        = 1'b1;
            emit_empty       = 1'b1;
            parse_phase_next = PH_HDR0;
          end else begin
            parse_phase_next = PH_DATA;
          end
        end
      end

      PH_DATA: begin
        emit                  = 1'b1;
        emit_byte             = masked_flag ? (rx_byte ^ key_byte) : rx_byte;
        key_index_next        = key_index + 2'd1;
        remaining_length_next = length_dec;
        if (length_dec == 64'd0) begin
          emit_last        = 1'b1;
          parse_phase_next = PH_HDR0;
        end
      end

      default: begin
        held_opcode_next = rx_byte[3:0] & OPCODE_MASK;
        parse_phase_next = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_HDR0;
      held_opcode      <= 4'd0;
      masked_flag      <= 1'b0;
      field_byte_count <= 3'd0;
      remaining_length <= 64'd0;
      masking_key      <= 32'd0;
      key_index        <= 2'd0;
    end else if (rx_xfer) begin
      parse_phase      <= parse_phase_next;
      held_opcode      <= held_opcode_next;
      masked_flag      <= masked_flag_next;
      field_byte_count <= field_byte_count_next;
      remaining_length <= remaining_length_next;
      masking_key      <= masking_key_next;
      key_index        <= key_index_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rx_xfer && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_xfer && emit) begin
      payload_byte <= emit_byte;
      frame_opcode <= held_opcode;
      frame_last   <= emit_last;
      empty_frame  <= emit_empty;
    end
  end

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && empty_frame |-> frame_last && payload_byte == 8'd0)
    else $error("empty frame marker without last flag or with nonzero byte");

  a_data_nonzero_len: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_DATA |-> remaining_length != 64'd0)
    else $error("payload phase entered with zero remaining length");

  a_hdr0_to_hdr1: assert property (@(posedge clk) disable iff (rst)
    rx_xfer && parse_phase == PH_HDR0 |=> parse_phase == PH_HDR1)
    else $error("first header byte did not advance to second");

  a_no_result_from_header: assert property (@(posedge clk) disable iff (rst)
    rx_xfer && parse_phase == PH_HDR0 && !result_ready |=> $stable(result_valid))
    else $error("first header byte produced a result");

  a_key_count_bound: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_KEY |-> field_byte_count <= KEY_LAST)
    else $error("masking key byte count out of range");
`endif

endmodule
`default_nettype wire
